>>> src/ryr_pkg.sv
// ---------------------------------------------------------------------------
// ryr_pkg: shared types and constants of the reference yaw rate block
// Register indexes, pipeline stage numbering and fixed-point constants.
// ---------------------------------------------------------------------------
package ryr_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_STEER  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_SPEED  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WHEEL_BASE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_UNDERSTEER = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_YAW_CAP    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FRICTION   = 3'd5;

   // fixed-point constants (Q.16)
   localparam logic [21:0] RAD2DEG_Q16 = 22'd3754936;
   localparam logic [25:0] FRIC_K_Q16  = 26'd36835925;
   localparam logic [14:0] FRIC_MIN_V  = 15'd26;

   // divider geometry
   localparam int QUO_W   = 34;
   localparam int DEN_W   = 40;
   localparam int FQUO_W  = 15;
   localparam int FREM_W  = 16;
   localparam logic [QUO_W-1:0] QUOT_SAT = 34'h2_0000_0000;

   // pipeline stage numbering
   localparam int ST_S1   = 0;
   localparam int ST_S2   = 1;
   localparam int ST_S3   = 2;
   localparam int ST_S4   = 3;
   localparam int ST_D0   = 4;
   localparam int ST_Y1   = ST_D0 + QUO_W;
   localparam int ST_Y2   = ST_Y1 + 1;
   localparam int ST_OUT  = ST_Y2 + 1;
   localparam int NUM_STG = ST_OUT + 1;

   // per-item flags that travel through the divider stages
   typedef struct packed {
      logic active;
      logic neg;
      logic fric_en;
      logic ovf;
      logic fric_ovf;
   } div_side_type;

endpackage

>>> src/ryr_div_step.sv
// ---------------------------------------------------------------------------
// ryr_div_step: one registered step of a restoring divider
// Shifts one numerator bit into the remainder and one quotient bit out.
// ---------------------------------------------------------------------------
module ryr_div_step #(
   parameter int REM_W  = 40,
   parameter int BITS_W = 34,
   parameter int DEN_W  = 40
) (
   input  logic              clock,
   input  logic              en,
   input  logic [REM_W-1:0]  rem_i,
   input  logic [BITS_W-1:0] bits_i,
   input  logic [DEN_W-1:0]  den_i,
   output logic [REM_W-1:0]  rem_o,
   output logic [BITS_W-1:0] bits_o,
   output logic [DEN_W-1:0]  den_o
);

   logic [REM_W:0]    trial;
   logic [REM_W:0]    diff;
   logic              qbit;
   logic [REM_W-1:0]  rem_in;
   logic [BITS_W-1:0] bits_in;
   logic [REM_W-1:0]  rem_ff;
   logic [BITS_W-1:0] bits_ff;
   logic [DEN_W-1:0]  den_ff;

   // trial subtract of the divisor
   always_comb begin
      trial   = {rem_i, bits_i[BITS_W-1]};
      diff    = trial - (REM_W+1)'(den_i);
      qbit    = (trial >= (REM_W+1)'(den_i));
      rem_in  = qbit ? diff[REM_W-1:0] : trial[REM_W-1:0];
      bits_in = {bits_i[BITS_W-2:0], qbit};
   end

   // step register
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         bits_ff <= bits_in;
         den_ff  <= den_i;
      end
   end

   assign rem_o  = rem_ff;
   assign bits_o = bits_ff;
   assign den_o  = den_ff;

endmodule

>>> src/reference_yaw_rate_top.sv
// ---------------------------------------------------------------------------
// reference_yaw_rate_top: target yaw rate from the steady-state bicycle model
// Pipelined fixed-point datapath with two restoring dividers.
// ---------------------------------------------------------------------------
// One request is accepted every cycle while the pipeline is not backed up by a
// response-side stall. The datapath has 41 register stages, the last of which
// presents the response. Most of them belong to the 34-step restoring division
// of the yaw quotient, one quotient bit per stage, with the friction-limit
// division running in 15 of those same stages. A stall on the response side
// only holds the stages that are occupied, so bubbles close up.
// Configuration registers are written through the csr_ port and are always
// ready; they should only be changed while no request is in flight.
// ---------------------------------------------------------------------------
module reference_yaw_rate_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [15:0]             req_steer_cmd,
   input  logic signed [15:0]             req_speed,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [15:0]             rsp_target_yaw,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ryr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ryr_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import ryr_pkg::*;

   // configuration registers
   logic [15:0] msa_ff;
   logic [14:0] mas_ff;
   logic [15:0] wb_ff;
   logic [23:0] ugr_ff;
   logic [14:0] cap_ff;
   logic [15:0] mu_ff;

   // pipeline control
   logic [NUM_STG:0]   adv;
   logic [NUM_STG-1:0] vld_in;
   logic [NUM_STG-1:0] vld_ff;

   // stage 1
   logic [14:0] v_in;
   logic [14:0] s1_v_ff;
   logic        s1_active_ff, s1_neg_ff, s1_fric_en_ff;
   logic [30:0] s1_a_ff;
   logic [15:0] s1_abs_ff;
   logic [29:0] s1_vv_ff;
   logic [41:0] s1_muc_ff;

   // stage 2
   logic signed [54:0] kv_in;
   logic [14:0] s2_v_ff;
   logic        s2_active_ff, s2_neg_ff, s2_fric_en_ff;
   logic [46:0] s2_b_ff;
   logic signed [54:0] s2_kv_ff;
   logic [25:0] s2_fx_ff;

   // stage 3
   logic signed [54:0] kv_rnd;
   logic [38:0] t_q;
   logic [40:0] dsum;
   logic [DEN_W-1:0] den_in;
   logic [14:0] s3_v_ff;
   logic        s3_active_ff, s3_neg_ff, s3_fric_en_ff;
   logic [46:0] s3_b_ff;
   logic [DEN_W-1:0] s3_den_ff;
   logic [25:0] s3_fx_ff;

   // divider lanes, index 0 is the stage 4 register
   logic [DEN_W-1:0]  m_rem  [0:QUO_W];
   logic [QUO_W-1:0]  m_bits [0:QUO_W];
   logic [DEN_W-1:0]  m_den  [0:QUO_W];
   logic [FREM_W-1:0] f_rem  [0:QUO_W];
   logic [FQUO_W-1:0] f_bits [0:QUO_W];
   logic [14:0]       f_den  [0:QUO_W];
   div_side_type      side_ff [0:QUO_W];
   div_side_type      side_in;

   // output stages
   logic [QUO_W-1:0] qmag;
   logic [14:0] fric_q;
   logic [14:0] lim_in;
   logic [38:0] y1_phi_ff, y1_plo_ff;
   logic [14:0] y1_lim_ff;
   logic        y1_active_ff, y1_neg_ff;
   logic [55:0] ysum;
   logic [16:0] y2_mag_ff;
   logic [14:0] y2_lim_ff;
   logic        y2_active_ff, y2_neg_ff;
   logic [14:0] clip;
   logic [15:0] yaw_in;
   logic [15:0] yaw_ff;

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         msa_ff <= 16'd6554;
         mas_ff <= 15'd256;
         wb_ff  <= 16'd6349;
         ugr_ff <= 24'd33554;
         cap_ff <= 15'd6400;
         mu_ff  <= 16'd19661;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MAX_STEER:  msa_ff <= csr_wdata[15:0];
            REG_MIN_SPEED:  mas_ff <= csr_wdata[14:0];
            REG_WHEEL_BASE: wb_ff  <= csr_wdata[15:0];
            REG_UNDERSTEER: ugr_ff <= csr_wdata[23:0];
            REG_YAW_CAP:    cap_ff <= csr_wdata[14:0];
            REG_FRICTION:   mu_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // advance chain: a stage moves when empty or when its successor moves
   always_comb begin
      adv[NUM_STG] = rsp_ready;
      for (int i = NUM_STG - 1; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      for (int i = 0; i < NUM_STG; i++) begin
         if (adv[i]) begin
            vld_in[i] = (i == 0) ? req_valid : vld_ff[(i == 0) ? 0 : i - 1];
         end else begin
            vld_in[i] = vld_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = adv[ST_S1];

   // stage 1: clip speed, first products
   assign v_in = req_speed[15] ? 15'd0 : req_speed[14:0];

   always_ff @(posedge clock) begin
      if (adv[ST_S1]) begin
         s1_v_ff       <= v_in;
         s1_active_ff  <= (v_in >= mas_ff);
         s1_neg_ff     <= req_steer_cmd[15];
         s1_fric_en_ff <= (v_in >= FRIC_MIN_V);
         s1_a_ff       <= 31'(v_in) * 31'(msa_ff);
         s1_abs_ff     <= req_steer_cmd[15] ? 16'(-req_steer_cmd) : req_steer_cmd;
         s1_vv_ff      <= 30'(v_in) * 30'(v_in);
         s1_muc_ff     <= 42'(mu_ff) * 42'(FRIC_K_Q16);
      end
   end

   // stage 2: numerator magnitude and understeer term
   assign kv_in = $signed(ugr_ff) * $signed({1'b0, s1_vv_ff});

   always_ff @(posedge clock) begin
      if (adv[ST_S2]) begin
         s2_v_ff       <= s1_v_ff;
         s2_active_ff  <= s1_active_ff;
         s2_neg_ff     <= s1_neg_ff;
         s2_fric_en_ff <= s1_fric_en_ff;
         s2_b_ff       <= 47'(s1_a_ff) * 47'(s1_abs_ff);
         s2_kv_ff      <= kv_in;
         s2_fx_ff      <= s1_muc_ff[41:16];
      end
   end

   // stage 3: denominator with floor at one lsb
   always_comb begin
      kv_rnd = s2_kv_ff[54] ? (s2_kv_ff + 55'sd65535) : s2_kv_ff;
      t_q    = kv_rnd[54:16];
      dsum   = {13'd0, wb_ff, 12'd0} + {{2{t_q[38]}}, t_q};
      den_in = (dsum[40] || (dsum == 41'd0)) ? 40'd1 : dsum[39:0];
   end

   always_ff @(posedge clock) begin
      if (adv[ST_S3]) begin
         s3_v_ff       <= s2_v_ff;
         s3_active_ff  <= s2_active_ff;
         s3_neg_ff     <= s2_neg_ff;
         s3_fric_en_ff <= s2_fric_en_ff;
         s3_b_ff       <= s2_b_ff;
         s3_den_ff     <= den_in;
         s3_fx_ff      <= s2_fx_ff;
      end
   end

   // stage 4: overflow checks and divider setup
   always_comb begin
      side_in.active   = s3_active_ff;
      side_in.neg      = s3_neg_ff;
      side_in.fric_en  = s3_fric_en_ff;
      side_in.ovf      = ({11'd0, s3_b_ff[46:18]} >= s3_den_ff);
      side_in.fric_ovf = ({4'd0, s3_fx_ff} >= {s3_v_ff, 15'd0});
   end

   always_ff @(posedge clock) begin
      if (adv[ST_S4]) begin
         side_ff[0] <= side_in;
         m_rem[0]   <= {11'd0, s3_b_ff[46:18]};
         m_bits[0]  <= {s3_b_ff[17:0], 16'd0};
         m_den[0]   <= s3_den_ff;
         f_rem[0]   <= {5'd0, s3_fx_ff[25:15]};
         f_bits[0]  <= s3_fx_ff[14:0];
         f_den[0]   <= s3_v_ff;
      end
   end

   // divider stages, one quotient bit each
   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      ryr_div_step #(
         .REM_W  (DEN_W),
         .BITS_W (QUO_W),
         .DEN_W  (DEN_W)
      ) u_main (
         .clock  (clock),
         .en     (adv[ST_D0+k]),
         .rem_i  (m_rem[k]),
         .bits_i (m_bits[k]),
         .den_i  (m_den[k]),
         .rem_o  (m_rem[k+1]),
         .bits_o (m_bits[k+1]),
         .den_o  (m_den[k+1])
      );

      if (k < FQUO_W) begin : g_fric
         ryr_div_step #(
            .REM_W  (FREM_W),
            .BITS_W (FQUO_W),
            .DEN_W  (15)
         ) u_fric (
            .clock  (clock),
            .en     (adv[ST_D0+k]),
            .rem_i  (f_rem[k]),
            .bits_i (f_bits[k]),
            .den_i  (f_den[k]),
            .rem_o  (f_rem[k+1]),
            .bits_o (f_bits[k+1]),
            .den_o  (f_den[k+1])
         );
      end else begin : g_hold
         // friction quotient is done, carry it along
         logic [FQUO_W-1:0] fq_ff;
         always_ff @(posedge clock) begin
            if (adv[ST_D0+k]) begin
               fq_ff <= f_bits[k];
            end
         end
         assign f_bits[k+1] = fq_ff;
         assign f_rem[k+1]  = '0;
         assign f_den[k+1]  = '0;
      end

      always_ff @(posedge clock) begin
         if (adv[ST_D0+k]) begin
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   // y1: saturate quotient, split scale product, pick the limit
   always_comb begin
      qmag   = (side_ff[QUO_W].ovf || (m_bits[QUO_W] > QUOT_SAT)) ? QUOT_SAT
                                                                  : m_bits[QUO_W];
      fric_q = f_bits[QUO_W];
      if (side_ff[QUO_W].fric_en && !side_ff[QUO_W].fric_ovf && (fric_q < cap_ff)) begin
         lim_in = fric_q;
      end else begin
         lim_in = cap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_Y1]) begin
         y1_phi_ff    <= 39'(qmag[33:17]) * 39'(RAD2DEG_Q16);
         y1_plo_ff    <= 39'(qmag[16:0]) * 39'(RAD2DEG_Q16);
         y1_lim_ff    <= lim_in;
         y1_active_ff <= side_ff[QUO_W].active;
         y1_neg_ff    <= side_ff[QUO_W].neg;
      end
   end

   // y2: combine partial products, keep the degree magnitude
   assign ysum = {y1_phi_ff, 17'd0} + 56'(y1_plo_ff);

   always_ff @(posedge clock) begin
      if (adv[ST_Y2]) begin
         y2_mag_ff    <= ysum[55:39];
         y2_lim_ff    <= y1_lim_ff;
         y2_active_ff <= y1_active_ff;
         y2_neg_ff    <= y1_neg_ff;
      end
   end

   // output: clamp, apply sign, zero below minimum speed
   always_comb begin
      clip = (y2_mag_ff > 17'(y2_lim_ff)) ? y2_lim_ff : y2_mag_ff[14:0];
      if (!y2_active_ff) begin
         yaw_in = 16'd0;
      end else if (y2_neg_ff) begin
         yaw_in = 16'(-{1'b0, clip});
      end else begin
         yaw_in = {1'b0, clip};
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_OUT]) begin
         yaw_ff <= yaw_in;
      end
   end

   assign rsp_valid      = vld_ff[ST_OUT];
   assign rsp_target_yaw = yaw_ff;

`ifndef SYNTH
   // result never exceeds the configured cap
   a_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (($signed(rsp_target_yaw) <= $signed({1'b0, cap_ff})) &&
                     ($signed(rsp_target_yaw) >= -$signed({1'b0, cap_ff}))))
      else $error("target yaw beyond cap");

   // main divider starts with remainder below divisor unless saturating
   a_main_pre: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[ST_S4] && !side_ff[0].ovf) |-> (m_rem[0] < m_den[0]))
      else $error("main divider precondition broken");

   // friction divider starts with remainder below speed when used
   a_fric_pre: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[ST_S4] && side_ff[0].fric_en && !side_ff[0].fric_ovf)
         |-> ({1'b0, f_den[0]} > f_rem[0]))
      else $error("friction divider precondition broken");

   // requests below minimum speed give zero
   a_inactive: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[ST_Y2] && adv[ST_OUT] && !y2_active_ff) |=> (rsp_target_yaw == 16'd0))
      else $error("inactive request gave nonzero yaw");
`endif

endmodule

>>> tb/reference_yaw_rate_chk.sv
// ---------------------------------------------------------------------------
// reference_yaw_rate_chk: result checker for the reference yaw rate block
// Tracks register writes, predicts the target yaw of every accepted request
// and compares each accepted response against the oldest prediction.
// ---------------------------------------------------------------------------
module reference_yaw_rate_chk (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic signed [15:0]             req_steer_cmd,
   input  logic signed [15:0]             req_speed,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic signed [15:0]             rsp_target_yaw,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [ryr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ryr_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             pending_count
);
   import ryr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // shadow copy of the configuration registers
   logic [15:0]        steer_gain;
   logic [14:0]        min_speed;
   logic [15:0]        base_len;
   logic signed [23:0] usteer_k;
   logic [14:0]        yaw_cap;
   logic [15:0]        mu;

   logic signed [15:0] yaw_queue[$];

   // bicycle model target yaw, saturated to the active limit
   function automatic logic signed [15:0] target_yaw_of(logic signed [15:0] steer,
                                                         logic signed [15:0] spd);
      longint v, delta, denom, quot, yaw, limit, fric;
      v = (spd > 0) ? longint'(spd) : 0;
      if (v < longint'(min_speed)) return 16'sd0;
      delta = longint'(steer) * longint'(steer_gain);
      denom = longint'(base_len) * 4096 + (longint'(usteer_k) * (v * v)) / 65536;
      if (denom < 1) denom = 1;
      quot = (v * delta * 65536) / denom;
      if (quot > (64'sd1 <<< 33)) quot = 64'sd1 <<< 33;
      if (quot < -(64'sd1 <<< 33)) quot = -(64'sd1 <<< 33);
      yaw = (quot * 3754936) / (64'sd1 <<< 39);
      limit = longint'(yaw_cap);
      if (v * 10 > 256) begin
         fric = (longint'(mu) * 36835925) / (v * 65536);
         if (fric < limit) limit = fric;
      end
      if (yaw > limit) yaw = limit;
      if (yaw < -limit) yaw = -limit;
      return yaw[15:0];
   endfunction

   // register shadow, prediction on request, compare on response
   always @(posedge clock) begin
      logic signed [15:0] exp_yaw;
      if (reset) begin
         steer_gain <= 16'd6554;
         min_speed  <= 15'd256;
         base_len   <= 16'd6349;
         usteer_k   <= 24'sd33554;
         yaw_cap    <= 15'd6400;
         mu         <= 16'd19661;
         yaw_queue.delete();
         fail_count    <= 0;
         pending_count <= 0;
      end else begin
         if (req_valid && req_ready)
            yaw_queue.push_back(target_yaw_of(req_steer_cmd, req_speed));
         if (rsp_valid && rsp_ready) begin
            if (yaw_queue.size() == 0) begin
               $error("unexpected response target_yaw=%0d", rsp_target_yaw);
               fail_count <= fail_count + 1;
            end else begin
               exp_yaw = yaw_queue.pop_front();
               if (exp_yaw !== rsp_target_yaw) begin
                  $error("target_yaw mismatch: expected %0d actual %0d",
                         exp_yaw, rsp_target_yaw);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= yaw_queue.size();
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MAX_STEER:  steer_gain <= csr_wdata[15:0];
               REG_MIN_SPEED:  min_speed  <= csr_wdata[14:0];
               REG_WHEEL_BASE: base_len   <= csr_wdata[15:0];
               REG_UNDERSTEER: usteer_k   <= csr_wdata[23:0];
               REG_YAW_CAP:    yaw_cap    <= csr_wdata[14:0];
               REG_FRICTION:   mu         <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
   end
endmodule

>>> tb/reference_yaw_rate_top_tb.sv
// ---------------------------------------------------------------------------
// reference_yaw_rate_top_tb: testbench for the reference yaw rate block
// Directed corner requests, then random requests over several register
// settings, with random gaps and stalls; checking is done by the checker.
// ---------------------------------------------------------------------------
module reference_yaw_rate_top_tb;
   import ryr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // index past the register list, writes to it are ignored
   localparam logic [CSR_IDX_W-1:0] REG_NONE = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic signed [15:0]    req_steer_cmd = '0;
   logic signed [15:0]    req_speed = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic signed [15:0]    rsp_target_yaw;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    fail_count;
   int                    pending_count;
   int                    hold_off = 0;
   logic                  long_hold = 1'b0;
   logic                  hold_taken = 1'b0;

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   reference_yaw_rate_top u_dut (.*);

   reference_yaw_rate_chk u_chk (.*);

   // random gap length, mostly short
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // response side stalls, with one long hold-off on demand
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (long_hold && !hold_taken) begin
         rsp_ready  <= 1'b0;
         hold_off   <= 300;
         hold_taken <= 1'b1;
      end else if (hold_off > 0) begin
         rsp_ready <= 1'b0;
         hold_off  <= hold_off - 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // valid stays high between back-to-back requests
   task automatic send_request(input logic signed [15:0] steer,
                               input logic signed [15:0] spd);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_steer_cmd <= steer;
      req_speed     <= spd;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // wait for every expected response, then let the pipeline drain
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // random speed, mostly in a realistic range
   function automatic logic signed [15:0] rand_speed();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return 16'($urandom_range(0, 12000));
      if (r < 8) return 16'($urandom_range(0, 60));
      return 16'($urandom);
   endfunction

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++)
         send_request(16'($urandom), rand_speed());
   endtask

   task automatic program_all(input logic [15:0] gain, input logic [14:0] vmin,
                              input logic [15:0] wb, input logic [23:0] k,
                              input logic [14:0] cap, input logic [15:0] fmu);
      write_reg(REG_MAX_STEER, 24'(gain));
      write_reg(REG_MIN_SPEED, 24'(vmin));
      write_reg(REG_WHEEL_BASE, 24'(wb));
      write_reg(REG_UNDERSTEER, k);
      write_reg(REG_YAW_CAP, 24'(cap));
      write_reg(REG_FRICTION, 24'(fmu));
      write_reg(REG_NONE, 24'hFFFFFF);
      csr_valid <= 1'b0;
   endtask

   // stimulus
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners at reset settings
      send_request(16'sh7FFF, 16'sh7FFF);
      send_request(16'sh8000, 16'sh7FFF);
      send_request(16'sh7FFF, 16'sh8000);
      send_request(16'sh1000, -16'sd500);
      send_request(16'sh4000, 16'sd255);
      send_request(16'sh4000, 16'sd256);
      send_request(16'sh8000, 16'sd25);
      send_request(16'sh8000, 16'sd26);
      send_request(16'sh0000, 16'sd3000);
      send_request(16'shFFFF, 16'sd1000);
      send_request(16'sh7FFF, 16'sd400);
      drain();

      // negative understeer floors the denominator, low speed threshold
      program_all(16'hFFFF, 15'd0, 16'd0, 24'h800000, 15'h7FFF, 16'hFFFF);
      send_request(16'sh7FFF, 16'sd0);
      send_request(16'sh7FFF, 16'sd25);
      send_request(16'sh7FFF, 16'sd26);
      send_request(16'sh8000, 16'sh7FFF);
      send_request(16'sh5555, 16'sd2000);
      drain();

      // zero cap and zero friction
      program_all(16'd6554, 15'd10, 16'd6349, 24'd33554, 15'd0, 16'd0);
      send_request(16'sh7FFF, 16'sd3000);
      send_request(16'sh8000, 16'sd20);
      drain();

      // random phases over several settings
      program_all(16'd6554, 15'd256, 16'd6349, 24'd33554, 15'd6400, 16'd19661);
      random_phase(500);
      drain();
      program_all(16'($urandom), 15'($urandom_range(0, 300)), 16'($urandom),
                  24'($urandom), 15'($urandom), 16'($urandom));
      random_phase(400);
      drain();
      program_all(16'hFFFF, 15'h7FFF, 16'hFFFF, 24'h7FFFFF, 15'h7FFF, 16'hFFFF);
      random_phase(200);
      drain();
      program_all(16'h8000, 15'd0, 16'd1, 24'hFF0000, 15'd3000, 16'd8000);

      // long receiver hold-off while requests keep coming
      long_hold <= 1'b1;
      random_phase(400);
      drain();
      program_all(16'($urandom), 15'($urandom_range(0, 2000)), 16'($urandom),
                  24'($urandom), 15'($urandom), 16'($urandom));
      random_phase(500);
      drain();

      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // run limit
   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end
endmodule

>>> filelist.f
src/ryr_pkg.sv
src/ryr_div_step.sv
src/reference_yaw_rate_top.sv
tb/reference_yaw_rate_chk.sv
tb/reference_yaw_rate_top_tb.sv
